@@ rtl/ffa_pkg.sv @@
// ffa_pkg: shared types, codes and constants of the first-fit block allocator.
// No dependencies.
`timescale 1ns / 1ps

package ffa_pkg;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 24;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_MEM  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET  = 32'd0;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'd65536;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND
    } state_t;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] base;
    } entry_t;

    typedef struct packed {
        logic            done;
        logic [SIZE_W:0] need;
    } round_t;

endpackage

@@ rtl/ffa_ram.sv @@
// ffa_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ffa_round.sv @@
// ffa_round: rounds a request size up to a multiple of the word size with a
// reciprocal multiply, result registered. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_round #(
    parameter int WORD_BYTES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [ffa_pkg::SIZE_W-1:0]  value,
    output ffa_pkg::round_t             result
);

    localparam int SUM_W   = ffa_pkg::SIZE_W + 1;
    localparam int SHIFT   = SUM_W + $clog2(WORD_BYTES);
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int SCALE_W = SUM_W + 5;
    localparam int CNT_W   = 2;

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WORD_BYTES) - 64'd1) / 64'(WORD_BYTES));
    localparam logic [CNT_W-1:0] STEPS = 2'd2;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   quot_reg, quot_next;
    logic [SUM_W-1:0]   need_reg, need_next;
    logic [PROD_W-1:0]  prod;
    logic [SCALE_W-1:0] scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        quot_reg <= quot_next;
        need_reg <= need_next;
    end

    // quotient of (size + word - 1) / word, then scaled back up
    assign prod   = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign scaled = SCALE_W'(quot_reg) * SCALE_W'(WORD_BYTES);

    always_comb
    begin
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        quot_next = SUM_W'(prod >> SHIFT);
        need_next = scaled[SUM_W-1:0];
        if (go)
        begin
            cnt_next = STEPS;
            sum_next = SUM_W'(value) + SUM_W'(WORD_BYTES - 1);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    assign result.done = (cnt_reg == '0);
    assign result.need = need_reg;

endmodule

@@ rtl/ffa_ctrl.sv @@
// ffa_ctrl: request sequencer; scans the block table in RAM, updates entries,
// appends blocks and forms results. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_ctrl #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          command,
    input  logic [ffa_pkg::SIZE_W-1:0]    size_bytes,
    input  logic [ffa_pkg::ADDR_W-1:0]    address,
    input  logic [ffa_pkg::ADDR_W-1:0]    heap_base,
    input  logic [ffa_pkg::ADDR_W-1:0]    heap_limit,
    input  ffa_pkg::round_t               round,
    input  ffa_pkg::entry_t               rd_data,
    output logic                          rd_en,
    output logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
    output logic                          wr_en,
    output logic [$clog2(MAX_BLOCKS)-1:0] wr_addr,
    output ffa_pkg::entry_t               wr_data,
    output logic                          busy,
    output logic                          done,
    output logic [ffa_pkg::ADDR_W-1:0]    data_address,
    output logic [ffa_pkg::STATUS_W-1:0]  status,
    output logic                          all_free
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = ffa_pkg::ADDR_W + 2;
    localparam logic [ffa_pkg::ADDR_W-1:0] HDR = ffa_pkg::ADDR_W'(HEADER_BYTES);

    ffa_pkg::state_t state_reg, state_next;

    logic                         cmd_reg, cmd_next;
    logic [ffa_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [ffa_pkg::ADDR_W-1:0]   target_reg, target_next;
    logic [CNT_W-1:0]             issue_reg, issue_next;
    logic [CNT_W-1:0]             check_reg, check_next;
    logic                         chk_valid_reg, chk_valid_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             used_cnt_reg, used_cnt_next;
    logic [ffa_pkg::ADDR_W-1:0]   top_reg, top_next;
    logic                         done_reg, done_next;
    logic [ffa_pkg::ADDR_W-1:0]   daddr_reg, daddr_next;
    logic [ffa_pkg::STATUS_W-1:0] status_reg, status_next;

    logic                         accept;
    logic                         hit;
    logic                         scan_end;
    logic                         no_fit;
    logic [SUM_W-1:0]             grow_end;
    logic [ffa_pkg::ADDR_W-1:0]   new_base;

    assign accept = start && (state_reg == ffa_pkg::ST_IDLE);

    assign hit = chk_valid_reg &&
                 (((cmd_reg == ffa_pkg::CMD_ALLOC) && !rd_data.used &&
                   (rd_data.size >= size_reg)) ||
                  ((cmd_reg == ffa_pkg::CMD_FREE) && (rd_data.base == target_reg)));

    assign scan_end = !chk_valid_reg && (issue_reg == count_reg);

    assign grow_end = SUM_W'(top_reg) + SUM_W'(round.need) + SUM_W'(HDR);
    assign new_base = heap_base + top_reg;
    assign no_fit   = round.need[ffa_pkg::SIZE_W] ||
                      (count_reg == CNT_W'(MAX_BLOCKS)) ||
                      (grow_end > SUM_W'(heap_limit));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffa_pkg::ST_IDLE;
            issue_reg     <= '0;
            check_reg     <= '0;
            chk_valid_reg <= 1'b0;
            count_reg     <= '0;
            used_cnt_reg  <= '0;
            top_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            check_reg     <= check_next;
            chk_valid_reg <= chk_valid_next;
            count_reg     <= count_next;
            used_cnt_reg  <= used_cnt_next;
            top_reg       <= top_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        size_reg   <= size_next;
        target_reg <= target_next;
        daddr_reg  <= daddr_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ffa_pkg::ST_SCAN;
                end
            end
            ffa_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ffa_pkg::ST_IDLE;
                end
                else if (scan_end)
                begin
                    state_next = (cmd_reg == ffa_pkg::CMD_ALLOC) ?
                                 ffa_pkg::ST_APPEND : ffa_pkg::ST_IDLE;
                end
            end
            ffa_pkg::ST_APPEND:
            begin
                if (round.done)
                begin
                    state_next = ffa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        target_next    = target_reg;
        issue_next     = issue_reg;
        check_next     = check_reg;
        chk_valid_next = 1'b0;
        count_next     = count_reg;
        used_cnt_next  = used_cnt_reg;
        top_next       = top_reg;
        done_next      = 1'b0;
        daddr_next     = daddr_reg;
        status_next    = status_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = check_reg[IDX_W-1:0];
        wr_data        = rd_data;
        case (state_reg)
            ffa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = command;
                    size_next   = size_bytes;
                    target_next = address - HDR;
                    issue_next  = '0;
                    check_next  = '0;
                end
            end
            ffa_pkg::ST_SCAN:
            begin
                if (!hit && (issue_reg != count_reg))
                begin
                    rd_en          = 1'b1;
                    issue_next     = issue_reg + 1'b1;
                    chk_valid_next = 1'b1;
                end
                if (chk_valid_reg)
                begin
                    check_next = check_reg + 1'b1;
                end
                if (hit)
                begin
                    wr_en      = 1'b1;
                    wr_data.used = (cmd_reg == ffa_pkg::CMD_ALLOC);
                    done_next  = 1'b1;
                    status_next = ffa_pkg::STATUS_OK;
                    if (cmd_reg == ffa_pkg::CMD_ALLOC)
                    begin
                        daddr_next    = rd_data.base + HDR;
                        used_cnt_next = used_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        daddr_next = '0;
                        if (rd_data.used)
                        begin
                            used_cnt_next = used_cnt_reg - 1'b1;
                        end
                    end
                end
                else if (scan_end && (cmd_reg == ffa_pkg::CMD_FREE))
                begin
                    done_next   = 1'b1;
                    daddr_next  = '0;
                    status_next = ffa_pkg::STATUS_UNKNOWN;
                end
            end
            ffa_pkg::ST_APPEND:
            begin
                if (round.done)
                begin
                    done_next = 1'b1;
                    if (no_fit)
                    begin
                        daddr_next  = '0;
                        status_next = ffa_pkg::STATUS_NO_MEM;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = count_reg[IDX_W-1:0];
                        wr_data.used  = 1'b1;
                        wr_data.size  = round.need[ffa_pkg::SIZE_W-1:0];
                        wr_data.base  = new_base;
                        count_next    = count_reg + 1'b1;
                        used_cnt_next = used_cnt_reg + 1'b1;
                        top_next      = grow_end[ffa_pkg::ADDR_W-1:0];
                        daddr_next    = new_base + HDR;
                        status_next   = ffa_pkg::STATUS_OK;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy         = (state_reg != ffa_pkg::ST_IDLE);
    assign done         = done_reg;
    assign data_address = daddr_reg;
    assign status       = status_reg;
    assign all_free     = (used_cnt_reg == '0);

endmodule

@@ rtl/first_fit_block_allocator.sv @@
// first_fit_block_allocator: top level with configuration registers, table RAM,
// size rounding unit and request sequencer. Depends on ffa_pkg, ffa_ram,
// ffa_round and ffa_ctrl.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. command
//   selects allocate (size_bytes) or free (address). busy stays high until the
//   request is complete; exactly one result follows on data_address, status
//   and all_free, valid for the single cycle in which done is high. The
//   receiver cannot stall; the result must be taken in that cycle.
//   The table is scanned one entry per cycle from the table RAM (one read
//   port, registered read). A hit raises done and ends the request. A free
//   that matches nothing ends once every entry has been read. An allocate with
//   no fitting free block, appended or refused, then waits in the append state
//   until the rounding unit is done. One request at a time: a new request is
//   taken only once busy is low.
//   Configuration writes (write_enable, write_index, write_data) take effect
//   at the edge; index 0 is heap_base, index 1 is heap_limit, others ignored.
//   Reset empties the table, sets the heap top to zero, heap_base to 0 and
//   heap_limit to 65536; no clearing pass is needed.
`timescale 1ns / 1ps

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int WORD_BYTES   = 8,
    parameter int HEADER_BYTES = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             command,
    input  logic [ffa_pkg::SIZE_W-1:0]       size_bytes,
    input  logic [ffa_pkg::ADDR_W-1:0]       address,
    output logic                             done,
    output logic [ffa_pkg::ADDR_W-1:0]       data_address,
    output logic [ffa_pkg::STATUS_W-1:0]     status,
    output logic                             all_free,
    input  logic                             write_enable,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]    write_index,
    input  logic [ffa_pkg::ADDR_W-1:0]       write_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    logic [ffa_pkg::ADDR_W-1:0] heap_base_reg, heap_base_next;
    logic [ffa_pkg::ADDR_W-1:0] heap_limit_reg, heap_limit_next;

    ffa_pkg::round_t round;
    ffa_pkg::entry_t rd_data;
    ffa_pkg::entry_t wr_data;
    logic            rd_en;
    logic            wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= ffa_pkg::HEAP_BASE_RESET;
            heap_limit_reg <= ffa_pkg::HEAP_LIMIT_RESET;
        end
        else
        begin
            heap_base_reg  <= heap_base_next;
            heap_limit_reg <= heap_limit_next;
        end
    end

    always_comb
    begin
        heap_base_next  = heap_base_reg;
        heap_limit_next = heap_limit_reg;
        if (write_enable)
        begin
            case (write_index)
                ffa_pkg::CFG_HEAP_BASE:  heap_base_next  = write_data;
                ffa_pkg::CFG_HEAP_LIMIT: heap_limit_next = write_data;
                default:
                begin
                end
            endcase
        end
    end

    ffa_ram #(
        .WIDTH ($bits(ffa_pkg::entry_t)),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ffa_round #(
        .WORD_BYTES (WORD_BYTES)
    ) u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (start && !busy),
        .value  (size_bytes),
        .result (round)
    );

    ffa_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .size_bytes   (size_bytes),
        .address      (address),
        .heap_base    (heap_base_reg),
        .heap_limit   (heap_limit_reg),
        .round        (round),
        .rd_data      (rd_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .busy         (busy),
        .done         (done),
        .data_address (data_address),
        .status       (status),
        .all_free     (all_free)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without a request in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ffa_pkg::STATUS_OK || status == ffa_pkg::STATUS_NO_MEM ||
                  status == ffa_pkg::STATUS_UNKNOWN))
        else $error("undefined status code");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ffa_pkg::STATUS_OK)) |-> (data_address == '0))
        else $error("failed request returned an address");
`endif

endmodule

@@ sim/tb_first_fit_block_allocator.sv @@
// tb_first_fit_block_allocator: self-checking bench for the first-fit block allocator.
// Predicts each allocate/free request and compares every result.
// Depends on ffa_pkg and first_fit_block_allocator.
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;

    localparam int MAX_BLOCKS   = 64;
    localparam int WORD_BYTES   = 8;
    localparam int HEADER_BYTES = 24;

    localparam int ADDR_W    = ffa_pkg::ADDR_W;
    localparam int SIZE_W    = ffa_pkg::SIZE_W;
    localparam int STATUS_W  = ffa_pkg::STATUS_W;
    localparam int CFG_IDX_W = ffa_pkg::CFG_IDX_W;

    localparam logic [ADDR_W-1:0]    HDR_OFFSET = HEADER_BYTES;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int                   SETTLE_CYCLES = 70;

    typedef struct packed {
        logic [ADDR_W-1:0]   data_address;
        logic [STATUS_W-1:0] status;
        logic                all_free;
    } outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 command = ffa_pkg::CMD_ALLOC;
    logic [SIZE_W-1:0]    size_bytes = '0;
    logic [ADDR_W-1:0]    address = '0;
    logic                 done;
    logic [ADDR_W-1:0]    data_address;
    logic [STATUS_W-1:0]  status;
    logic                 all_free;
    logic                 write_enable = 1'b0;
    logic [CFG_IDX_W-1:0] write_index = ffa_pkg::CFG_HEAP_BASE;
    logic [ADDR_W-1:0]    write_data = '0;

    // allocator mirror
    logic [ADDR_W-1:0] blk_base [MAX_BLOCKS];
    logic [SIZE_W-1:0] blk_size [MAX_BLOCKS];
    bit                blk_used [MAX_BLOCKS];
    int                blk_count = 0;
    logic [ADDR_W-1:0] top_offset = '0;
    logic [ADDR_W-1:0] cfg_base = ffa_pkg::HEAP_BASE_RESET;
    logic [ADDR_W-1:0] cfg_limit = ffa_pkg::HEAP_LIMIT_RESET;

    outcome_t          expected_outcomes[$];
    logic [ADDR_W-1:0] live_addrs[$];
    logic [ADDR_W-1:0] freed_addrs[$];
    int                error_count = 0;
    bit                idle_enable = 1'b1;

    first_fit_block_allocator #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .WORD_BYTES   (WORD_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .size_bytes   (size_bytes),
        .address      (address),
        .done         (done),
        .data_address (data_address),
        .status       (status),
        .all_free     (all_free),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_first_fit_block_allocator: done, errors");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            blk_used[i] = 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        $display("%0t: mismatch %s: got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    function automatic outcome_t compute_outcome(input logic cmd,
                                                 input logic [SIZE_W-1:0] req_size,
                                                 input logic [ADDR_W-1:0] req_addr);
        outcome_t        res;
        longint unsigned need;
        longint unsigned cost;
        longint unsigned reach;
        bit              found;
        res.data_address = '0;
        res.status = ffa_pkg::STATUS_OK;
        res.all_free = 1'b1;
        found = 1'b0;
        if (cmd == ffa_pkg::CMD_ALLOC)
        begin
            need = 64'(req_size);
            need = ((need + 64'(WORD_BYTES) - 64'd1) / 64'(WORD_BYTES)) * 64'(WORD_BYTES);
            if (need > 64'hFF_FFFF)
                res.status = ffa_pkg::STATUS_NO_MEM;
            else
            begin
                for (int i = 0; i < blk_count; i++)
                begin
                    if (!found && !blk_used[i] && 64'(blk_size[i]) >= need)
                    begin
                        found = 1'b1;
                        blk_used[i] = 1'b1;
                        res.data_address = blk_base[i] + HDR_OFFSET;
                    end
                end
                if (!found)
                begin
                    cost = need + 64'(HEADER_BYTES);
                    reach = 64'(top_offset);
                    reach = reach + cost;
                    if (blk_count >= MAX_BLOCKS || reach > 64'(cfg_limit))
                        res.status = ffa_pkg::STATUS_NO_MEM;
                    else
                    begin
                        blk_base[blk_count] = cfg_base + top_offset;
                        blk_size[blk_count] = need[SIZE_W-1:0];
                        blk_used[blk_count] = 1'b1;
                        res.data_address = blk_base[blk_count] + HDR_OFFSET;
                        blk_count++;
                        top_offset = reach[ADDR_W-1:0];
                    end
                end
            end
        end
        else
        begin
            for (int i = 0; i < blk_count; i++)
            begin
                if (!found && blk_base[i] + HDR_OFFSET == req_addr)
                begin
                    found = 1'b1;
                    blk_used[i] = 1'b0;
                end
            end
            if (!found)
                res.status = ffa_pkg::STATUS_UNKNOWN;
        end
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_used[i])
                res.all_free = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
                report_mismatch("result with no request", data_address, '0);
            else
            begin
                want = expected_outcomes.pop_front();
                if (data_address !== want.data_address)
                    report_mismatch("data_address", data_address, want.data_address);
                if (status !== want.status)
                    report_mismatch("status", ADDR_W'(status), ADDR_W'(want.status));
                if (all_free !== want.all_free)
                    report_mismatch("all_free", ADDR_W'(all_free), ADDR_W'(want.all_free));
            end
        end
    end

    task automatic issue_request(input logic cmd, input logic [SIZE_W-1:0] sz,
                                 input logic [ADDR_W-1:0] ad);
        outcome_t res;
        int       hit;
        if (idle_enable && $urandom_range(99) < 33)
        begin
            start <= 1'b0;
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 70)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        size_bytes <= sz;
        address <= ad;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        res = compute_outcome(cmd, sz, ad);
        expected_outcomes.push_back(res);
        if (res.status == ffa_pkg::STATUS_OK)
        begin
            if (cmd == ffa_pkg::CMD_ALLOC)
                live_addrs.push_back(res.data_address);
            else
            begin
                hit = -1;
                for (int i = 0; i < live_addrs.size(); i++)
                begin
                    if (hit < 0 && live_addrs[i] == ad)
                        hit = i;
                end
                if (hit >= 0)
                    live_addrs.delete(hit);
                freed_addrs.push_back(ad);
                if (freed_addrs.size() > 64)
                    void'(freed_addrs.pop_front());
            end
        end
    endtask

    task automatic wait_for_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_outcomes.size() != 0 || busy);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        write_enable <= 1'b1;
        write_index <= idx;
        write_data <= value;
        @(posedge clk);
        if (idx == ffa_pkg::CFG_HEAP_BASE)
            cfg_base = value;
        else if (idx == ffa_pkg::CFG_HEAP_LIMIT)
            cfg_limit = value;
        write_enable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_empty_table();
        issue_request(ffa_pkg::CMD_FREE, '0, '0);
        issue_request(ffa_pkg::CMD_ALLOC, '0, 32'hFFFF_FFFF);
        issue_request(ffa_pkg::CMD_FREE, 24'hFF_FFFF, 32'd24);
        issue_request(ffa_pkg::CMD_FREE, '0, 32'd24);
    endtask

    task automatic test_rounding_and_limits();
        issue_request(ffa_pkg::CMD_ALLOC, 24'd1, '0);
        issue_request(ffa_pkg::CMD_ALLOC, '0, '0);
        issue_request(ffa_pkg::CMD_ALLOC, 24'hFF_FFFF, '0);
        issue_request(ffa_pkg::CMD_ALLOC, 24'hFF_FFF9, '0);
        issue_request(ffa_pkg::CMD_ALLOC, 24'hFF_FFF8, '0);
        issue_request(ffa_pkg::CMD_FREE, '0, 32'd24);
        issue_request(ffa_pkg::CMD_FREE, '0, 32'hFFFF_FFFF);
    endtask

    task automatic test_block_reuse();
        wait_for_idle();
        write_cfg(ffa_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        issue_request(ffa_pkg::CMD_ALLOC, 24'hFF_FFF8, '0);
        issue_request(ffa_pkg::CMD_FREE, '0, live_addrs[live_addrs.size() - 1]);
        issue_request(ffa_pkg::CMD_ALLOC, 24'd100, '0);
        wait_for_idle();
        write_cfg(ffa_pkg::CFG_HEAP_LIMIT, '0);
        issue_request(ffa_pkg::CMD_FREE, '0, live_addrs[live_addrs.size() - 1]);
        issue_request(ffa_pkg::CMD_ALLOC, 24'd5, '0);
        issue_request(ffa_pkg::CMD_ALLOC, 24'd5, '0);
        wait_for_idle();
        write_cfg(CFG_SPARE_2, 32'hFFFF_FFFF);
        write_cfg(CFG_SPARE_3, 32'hFFFF_FFFF);
        issue_request(ffa_pkg::CMD_ALLOC, 24'd9, '0);
    endtask

    task automatic test_base_rewrite();
        wait_for_idle();
        write_cfg(ffa_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        // next block lands on the same user address as the first one
        write_cfg(ffa_pkg::CFG_HEAP_BASE, '0 - top_offset);
        issue_request(ffa_pkg::CMD_ALLOC, 24'd8, '0);
        issue_request(ffa_pkg::CMD_FREE, '0, 32'd24);
        issue_request(ffa_pkg::CMD_FREE, '0, 32'd24);
        wait_for_idle();
        // user address wraps past the top of the address space
        write_cfg(ffa_pkg::CFG_HEAP_BASE, 32'hFFFF_FFF0 - top_offset);
        issue_request(ffa_pkg::CMD_ALLOC, 24'd16, '0);
        issue_request(ffa_pkg::CMD_FREE, '0, 32'd8);
    endtask

    task automatic random_request();
        int                pick;
        logic [SIZE_W-1:0] sz;
        logic [ADDR_W-1:0] ad;
        sz = SIZE_W'($urandom);
        ad = $urandom;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                sz = SIZE_W'($urandom_range(64));
            else if (pick < 85)
                sz = SIZE_W'($urandom_range(4096));
            else if (pick < 95)
                sz = SIZE_W'($urandom);
            else
                sz = 24'hFF_FFF0 + SIZE_W'($urandom_range(15));
            issue_request(ffa_pkg::CMD_ALLOC, sz, ad);
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 70 && live_addrs.size() > 0)
                ad = live_addrs[$urandom_range(live_addrs.size() - 1)];
            else if (pick < 85 && freed_addrs.size() > 0)
                ad = freed_addrs[$urandom_range(freed_addrs.size() - 1)];
            issue_request(ffa_pkg::CMD_FREE, sz, ad);
        end
    endtask

    task automatic test_random_traffic(input int count, input int quiet_count);
        for (int n = 0; n < count; n++)
        begin
            idle_enable = (n >= quiet_count);
            if ($urandom_range(59) == 0)
                wait_for_idle();
            random_request();
        end
        idle_enable = 1'b1;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_rounding_and_limits();
        test_block_reuse();
        test_base_rewrite();

        wait_for_idle();
        write_cfg(ffa_pkg::CFG_HEAP_BASE, $urandom);
        write_cfg(ffa_pkg::CFG_HEAP_LIMIT, top_offset + 32'd3000);
        test_random_traffic(250, 0);

        wait_for_idle();
        write_cfg(ffa_pkg::CFG_HEAP_BASE, '0);
        write_cfg(ffa_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        test_random_traffic(250, 120);

        wait_for_idle();
        write_cfg(ffa_pkg::CFG_HEAP_BASE, 32'hFFFF_FFFF);
        write_cfg(ffa_pkg::CFG_HEAP_LIMIT, '0);
        test_random_traffic(300, 0);

        wait_for_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_outcomes.size() != 0)
            report_mismatch("results missing", expected_outcomes.size(), '0);
        if (error_count == 0)
            $display("tb_first_fit_block_allocator: done, clean");
        else
            $display("tb_first_fit_block_allocator: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/ffa_round.sv
rtl/ffa_ctrl.sv
rtl/first_fit_block_allocator.sv
sim/tb_first_fit_block_allocator.sv
